// ===== rtl/nearest_target_go_to_goal_controller_defines.svh =====
// Assertion macros used by the controller (ngtg_ctrl).
`ifndef NEAREST_TARGET_GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define NEAREST_TARGET_GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// Same-cycle implication under reset.
`define NGTG_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define NGTG_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ngtg_pkg.sv =====
package ngtg_pkg;

	// Item commands
	localparam logic [1:0] CMD_POSE   = 2'd0;
	localparam logic [1:0] CMD_CAND   = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_LIN_GAIN = 3'd0;
	localparam logic [2:0] REG_ANG_GAIN = 3'd1;
	localparam logic [2:0] REG_DEADZONE = 3'd2;
	localparam logic [2:0] REG_HOME_X   = 3'd3;
	localparam logic [2:0] REG_HOME_Y   = 3'd4;
	localparam logic [2:0] REG_SEARCH   = 3'd5;

	localparam int PADDR_W = 5;

	// Angles in Q3.13
	localparam logic signed [17:0] ANG_PI      = 18'sd25736;
	localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
	localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;

	// Sequencer lengths
	localparam logic [4:0] CORDIC_STEPS = 5'd14;
	localparam logic [4:0] ITER_LAST    = 5'd16;

	localparam logic signed [15:0] GOAL_RESET = 16'sd11264;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POSE,
		S_CAND_SQ,
		S_CAND_UPD,
		S_TICK_SQ,
		S_TICK_CHK,
		S_TICK_ITER,
		S_TICK_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]  lin_gain;
		logic [7:0]  ang_gain;
		logic [15:0] deadzone;
		logic [14:0] home_x;
		logic [14:0] home_y;
		logic [14:0] search_limit;
	} cfg_t;

	typedef struct packed {
		logic ld_item;
		logic ld_pose;
		logic cand_sq;
		logic cand_upd;
		logic tick_sq;
		logic iter_init;
		logic iter_step;
		logic cordic_en;
		logic fin_mul;
		logic ld_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] item_cmd;
		logic       in_zone;
	} dp_stat_t;

	// CORDIC arctangent table, Q3.13
	function automatic logic signed [17:0] atan_lut(input logic [3:0] idx);
		logic signed [17:0] v;
		case (idx)
			4'd0:    v = 18'sd6434;
			4'd1:    v = 18'sd3798;
			4'd2:    v = 18'sd2007;
			4'd3:    v = 18'sd1019;
			4'd4:    v = 18'sd511;
			4'd5:    v = 18'sd256;
			4'd6:    v = 18'sd128;
			4'd7:    v = 18'sd64;
			4'd8:    v = 18'sd32;
			4'd9:    v = 18'sd16;
			4'd10:   v = 18'sd8;
			4'd11:   v = 18'sd4;
			4'd12:   v = 18'sd2;
			4'd13:   v = 18'sd1;
			default: v = 18'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/ngtg_in_if.sv =====
interface ngtg_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] heading;
	logic              entry_valid;
	logic              last_entry;

	modport source(output valid, command, pos_x, pos_y, heading, entry_valid, last_entry,
		input ready);
	modport sink(input valid, command, pos_x, pos_y, heading, entry_valid, last_entry,
		output ready);
endinterface

// ===== rtl/ngtg_out_if.sv =====
interface ngtg_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       linear_speed;
	logic signed [16:0] angular_rate;
	logic              at_target;

	modport source(output valid, linear_speed, angular_rate, at_target, input ready);
	modport sink(input valid, linear_speed, angular_rate, at_target, output ready);
endinterface

// ===== rtl/ngtg_datapath.sv =====
module ngtg_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ngtg_pkg::cfg_t     cfg,
	input  ngtg_pkg::dp_cmd_t  cmd,
	input  logic [4:0]         step_idx,
	input  logic [1:0]         command,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic               entry_valid,
	input  logic               last_entry,
	output ngtg_pkg::dp_stat_t stat,
	output logic [15:0]        linear_speed,
	output logic signed [16:0] angular_rate,
	output logic               at_target
);
	import ngtg_pkg::*;

	// Latched item
	logic [1:0]         it_cmd_q;
	logic signed [15:0] it_x_q, it_y_q, it_hd_q;
	logic               it_ev_q, it_last_q;

	// Pose, goal and list state
	logic signed [15:0] robot_x_q, robot_y_q, robot_hd_q;
	logic signed [15:0] goal_x_q, goal_y_q, best_x_q, best_y_q;
	logic [31:0]        best_d2_q;
	logic               in_list_q;

	// Squares
	logic [32:0] sqa_q, sqb_q;
	logic [31:0] dz2_q;
	logic        zone_q, zvec_q;

	// Iteration state
	logic [33:0]        n_q;
	logic [19:0]        rem_q;
	logic [16:0]        root_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [17:0] cz_q;

	// Final products
	logic [24:0]        sp_prod_q;
	logic signed [26:0] rt_prod_q;

	// Output word
	logic [15:0]        speed_q;
	logic signed [16:0] rate_q;
	logic               at_q;

	logic signed [16:0] dx, dy, ex, ey, opa, opb;
	logic signed [33:0] pa, pb;
	logic [33:0]        d2_sum;
	logic [31:0]        d2_sat;
	logic               cand_better;
	logic [31:0]        best_d2_cur;
	logic signed [15:0] best_x_cur, best_y_cur;
	logic signed [33:0] xi, yi, xs, ys;
	logic [19:0]        rem_sh, trial;
	logic signed [17:0] z_eff, e_raw, e_wrap;
	logic signed [20:0] rt_shift;

	// Error vectors and shared square multipliers
	assign dx  = 17'(robot_x_q) - 17'(it_x_q);
	assign dy  = 17'(robot_y_q) - 17'(it_y_q);
	assign ex  = 17'(goal_x_q) - 17'(robot_x_q);
	assign ey  = 17'(goal_y_q) - 17'(robot_y_q);
	assign opa = cmd.tick_sq ? ex : dx;
	assign opb = cmd.tick_sq ? ey : dy;
	assign pa  = opa * opa;
	assign pb  = opb * opb;

	assign d2_sum = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign d2_sat = (d2_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : d2_sum[31:0];

	// Best candidate as seen in this update (list start already applied)
	assign best_d2_cur = best_d2_q;
	assign cand_better = it_ev_q && (d2_sat < best_d2_cur);
	assign best_x_cur  = cand_better ? it_x_q : best_x_q;
	assign best_y_cur  = cand_better ? it_y_q : best_y_q;

	// CORDIC operands
	assign xi = {{3{ex[16]}}, ex, 14'd0};
	assign yi = {{3{ey[16]}}, ey, 14'd0};
	assign xs = cx_q >>> step_idx;
	assign ys = cy_q >>> step_idx;

	// Square root step
	assign rem_sh = {rem_q[17:0], n_q[33:32]};
	assign trial  = {1'b0, root_q, 2'b01};

	// Heading error, wrapped once
	assign z_eff  = zvec_q ? 18'sd0 : cz_q;
	assign e_raw  = z_eff - 18'(it_hd_q);
	always_comb begin
		if (e_raw < -ANG_PI)
			e_wrap = e_raw + ANG_TWO_PI;
		else if (e_raw > ANG_PI)
			e_wrap = e_raw - ANG_TWO_PI;
		else
			e_wrap = e_raw;
	end

	assign rt_shift = 21'(rt_prod_q >>> 6);

	// Item latch
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			it_cmd_q  <= command;
			it_x_q    <= pos_x;
			it_y_q    <= pos_y;
			it_hd_q   <= heading;
			it_ev_q   <= entry_valid;
			it_last_q <= last_entry;
		end else if (cmd.tick_sq) begin
			// tick uses the stored heading
			it_hd_q <= robot_hd_q;
		end
	end

	// Pose, goal and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_x_q  <= '0;
			robot_y_q  <= '0;
			robot_hd_q <= '0;
			goal_x_q   <= GOAL_RESET;
			goal_y_q   <= GOAL_RESET;
			best_x_q   <= '0;
			best_y_q   <= '0;
			best_d2_q  <= '0;
			in_list_q  <= 1'b0;
		end else begin
			if (cmd.ld_pose) begin
				robot_x_q  <= it_x_q;
				robot_y_q  <= it_y_q;
				robot_hd_q <= it_hd_q;
			end
			if (cmd.cand_sq && !in_list_q) begin
				best_d2_q <= {17'd0, cfg.search_limit} * {17'd0, cfg.search_limit};
				best_x_q  <= 16'({1'b0, cfg.home_x});
				best_y_q  <= 16'({1'b0, cfg.home_y});
				in_list_q <= 1'b1;
			end
			if (cmd.cand_upd) begin
				if (cand_better) begin
					best_d2_q <= d2_sat;
					best_x_q  <= it_x_q;
					best_y_q  <= it_y_q;
				end
				if (it_last_q) begin
					goal_x_q  <= best_x_cur;
					goal_y_q  <= best_y_cur;
					in_list_q <= 1'b0;
				end
			end
		end
	end

	// Squares and deadzone bound
	always_ff @(posedge clk) begin
		if (cmd.cand_sq || cmd.tick_sq) begin
			sqa_q <= pa[32:0];
			sqb_q <= pb[32:0];
		end
		if (cmd.tick_sq)
			dz2_q <= cfg.deadzone * cfg.deadzone;
	end

	// Square root and CORDIC iterations
	always_ff @(posedge clk) begin
		if (cmd.iter_init) begin
			zone_q <= d2_sum < {2'b00, dz2_q};
			zvec_q <= (ex == 17'sd0) && (ey == 17'sd0);
			n_q    <= d2_sum;
			rem_q  <= '0;
			root_q <= '0;
			if (xi < 0) begin
				if (yi >= 0) begin
					cx_q <= yi;
					cy_q <= -xi;
					cz_q <= ANG_HALF_PI;
				end else begin
					cx_q <= -yi;
					cy_q <= xi;
					cz_q <= -ANG_HALF_PI;
				end
			end else begin
				cx_q <= xi;
				cy_q <= yi;
				cz_q <= '0;
			end
		end else if (cmd.iter_step) begin
			n_q <= {n_q[31:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[15:0], 1'b0};
			end
			if (cmd.cordic_en) begin
				if (!cy_q[33]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_lut(step_idx[3:0]);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_lut(step_idx[3:0]);
				end
			end
		end
	end

	// Gain products
	always_ff @(posedge clk) begin
		if (cmd.fin_mul) begin
			sp_prod_q <= root_q * cfg.lin_gain;
			rt_prod_q <= e_wrap * $signed({1'b0, cfg.ang_gain});
		end
	end

	// Output word with saturation
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			if (zone_q) begin
				speed_q <= '0;
				rate_q  <= '0;
				at_q    <= 1'b1;
			end else begin
				speed_q <= (sp_prod_q[24:20] != 5'd0) ? 16'hFFFF : sp_prod_q[19:4];
				if (rt_shift > 21'sd65535)
					rate_q <= 17'sd65535;
				else if (rt_shift < -21'sd65536)
					rate_q <= -17'sd65536;
				else
					rate_q <= rt_shift[16:0];
				at_q <= 1'b0;
			end
		end
	end

	assign stat.item_cmd = it_cmd_q;
	assign stat.in_zone  = d2_sum < {2'b00, dz2_q};

	assign linear_speed = speed_q;
	assign angular_rate = rate_q;
	assign at_target    = at_q;
endmodule

// ===== rtl/ngtg_ctrl.sv =====
`include "nearest_target_go_to_goal_controller_defines.svh"

module ngtg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ngtg_pkg::dp_stat_t stat,
	output ngtg_pkg::dp_cmd_t  cmd,
	output logic [4:0]         step_idx
);
	import ngtg_pkg::*;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q, out_valid_d;

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = S_POSE;
				end
			end
			S_POSE: begin
				// dispatch on the latched command; unused code just returns
				case (stat.item_cmd)
					CMD_POSE: begin
						cmd.ld_pose = 1'b1;
						state_d     = S_IDLE;
					end
					CMD_CAND: state_d = S_CAND_SQ;
					CMD_TICK: state_d = S_TICK_SQ;
					default:  state_d = S_IDLE;
				endcase
			end
			S_CAND_SQ: begin
				cmd.cand_sq = 1'b1;
				state_d     = S_CAND_UPD;
			end
			S_CAND_UPD: begin
				cmd.cand_upd = 1'b1;
				state_d      = S_IDLE;
			end
			S_TICK_SQ: begin
				cmd.tick_sq = 1'b1;
				state_d     = S_TICK_CHK;
			end
			S_TICK_CHK: begin
				cmd.iter_init = 1'b1;
				cnt_d         = '0;
				state_d       = stat.in_zone ? S_TICK_OUT : S_TICK_ITER;
			end
			S_TICK_ITER: begin
				cmd.iter_step = 1'b1;
				cmd.cordic_en = cnt_q < CORDIC_STEPS;
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == ITER_LAST) begin
					cmd.fin_mul = 1'b0;
					state_d     = S_TICK_OUT;
				end
			end
			S_TICK_OUT: begin
				// after the iteration loop, one extra pass computes the gain products first
				if (cnt_q == ITER_LAST + 5'd1) begin
					cmd.fin_mul = 1'b1;
					cnt_d       = '0;
				end else if (!out_valid_q || out_ready) begin
					cmd.ld_out  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign step_idx  = cnt_q;

	`NGTG_ASSERT_NEXT(a_out_load, clk, arst_n, cmd.ld_out, out_valid_q, "output not flagged after load")
	`NGTG_ASSERT_NOW(a_cnt_range, clk, arst_n, state_q == S_TICK_ITER, cnt_q <= ITER_LAST, "iteration count overrun")
	`NGTG_ASSERT_NEXT(a_iter_exit, clk, arst_n, (state_q == S_TICK_ITER) && (cnt_q == ITER_LAST), state_q == S_TICK_OUT, "iteration did not finish")
	`NGTG_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.ld_out, !out_valid_q || out_ready, "output word overwritten")
endmodule

// ===== rtl/nearest_target_go_to_goal_controller.sv =====
// Nearest-target go-to-goal controller.
// Input channel in_ch carries one word per item: command 0 stores the robot
// pose, command 1 is a candidate in a list closed by last_entry, command 2 is a
// control tick. Only ticks produce an output word on out_ch (linear_speed,
// angular_rate, at_target); command 3 is dropped.
// Flow: the input is taken one item at a time. A tick is squared and checked
// against the deadzone; outside it, the 17-step bit-serial square root runs
// alongside the 14-step CORDIC angle search in one shared iteration loop,
// followed by a gain-product pass, before the tick's word is loaded.
// A finished word sits in the output register; the next item is accepted
// while it waits. A tick that completes while that word is still unread holds
// in its last state until out_ch.ready frees the register.
// The gains, deadzone, home point and search limit are written over the APB
// port; the user must write them only while the block is idle, the block
// itself does not enforce this. Reset (arst_n low) restores register defaults,
// clears the pose, sets the goal to 5.5/5.5 and drops any pending word.
module nearest_target_go_to_goal_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	ngtg_in_if.sink                       in_ch,
	ngtg_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ngtg_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ngtg_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [4:0] step_idx;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_gain     <= 8'd32;
			cfg_q.ang_gain     <= 8'd96;
			cfg_q.deadzone     <= 16'd410;
			cfg_q.home_x       <= 15'd11355;
			cfg_q.home_y       <= 15'd11355;
			cfg_q.search_limit <= 15'd31949;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LIN_GAIN: cfg_q.lin_gain     <= pwdata[7:0];
				REG_ANG_GAIN: cfg_q.ang_gain     <= pwdata[7:0];
				REG_DEADZONE: cfg_q.deadzone     <= pwdata[15:0];
				REG_HOME_X:   cfg_q.home_x       <= pwdata[14:0];
				REG_HOME_Y:   cfg_q.home_y       <= pwdata[14:0];
				REG_SEARCH:   cfg_q.search_limit <= pwdata[14:0];
				default:      ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_LIN_GAIN: prdata = {24'd0, cfg_q.lin_gain};
			REG_ANG_GAIN: prdata = {24'd0, cfg_q.ang_gain};
			REG_DEADZONE: prdata = {16'd0, cfg_q.deadzone};
			REG_HOME_X:   prdata = {17'd0, cfg_q.home_x};
			REG_HOME_Y:   prdata = {17'd0, cfg_q.home_y};
			REG_SEARCH:   prdata = {17'd0, cfg_q.search_limit};
			default:      prdata = '0;
		endcase
	end

	ngtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.step_idx  (step_idx)
	);

	ngtg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.step_idx     (step_idx),
		.command      (in_ch.command),
		.pos_x        (in_ch.pos_x),
		.pos_y        (in_ch.pos_y),
		.heading      (in_ch.heading),
		.entry_valid  (in_ch.entry_valid),
		.last_entry   (in_ch.last_entry),
		.stat         (stat),
		.linear_speed (out_ch.linear_speed),
		.angular_rate (out_ch.angular_rate),
		.at_target    (out_ch.at_target)
	);
endmodule
